/* design/astl_pkg.sv */
// ----------------------------------------------------------------------------
// astl_pkg: shared types, constants and tanh table
// Register indexes, controller command type, fixed-point constants and the
// interpolation points of tanh over [0,4], built at elaboration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package astl_pkg;

   localparam int CHANNELS_DEFAULT = 2;

   // tanh table: TANH_DEPTH+1 points in Q1.23 over [0,4], power of two
   localparam int TANH_DEPTH = 256;
   localparam int TANH_IDX_W = $clog2(TANH_DEPTH);
   localparam int SPAN_SHIFT = 25;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 25;

   localparam logic [CSR_INDEX_W-1:0] REG_DRIVE_GAIN   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DRIVE_AMOUNT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SHOCK_AMOUNT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_MIX_AMOUNT   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_TILT_AMOUNT  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_CEILING      = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_TONE_COEF    = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_ACCUMULATE   = 3'd7;

   // reset values
   localparam logic [22:0] RST_DRIVE_GAIN = 23'd65536;
   localparam logic [16:0] RST_MIX_AMOUNT = 17'd65536;
   localparam logic [22:0] RST_CEILING    = 23'd8083000;
   localparam logic [24:0] RST_TONE_COEF  = 25'd13000000;

   // fixed-point constants
   localparam logic [16:0] ONE_Q16     = 17'd65536;
   localparam logic [24:0] ONE_Q24     = 25'd16777216;
   localparam logic [23:0] ONE_Q23     = 24'd8388608;
   localparam logic [16:0] CLEAN_LIMIT = 17'd6;
   localparam logic [16:0] FOLD_LIMIT  = 17'd65;
   localparam logic [13:0] BIAS_Q16    = 14'd9830;
   localparam logic [16:0] SLOPE_POS   = 17'd104858;
   localparam logic [16:0] SLOPE_NEG   = 17'd85197;
   localparam logic [15:0] FOLD_Q16    = 16'd39322;
   localparam logic [23:0] CLAMP_Q23   = 24'd10066330;
   localparam logic [22:0] S24_MAX     = 23'd8388607;
   localparam logic [16:0] TILT_MAX    = 17'sd32768;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DRIVE, ST_SCALE, ST_ARG, ST_TANH, ST_INTERP, ST_BLEND1,
      ST_BLEND2, ST_TONE1, ST_TONE2, ST_LP, ST_TILT, ST_MIX1, ST_MIX2, ST_OUT
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_DRIVE, OP_SCALE, OP_ARG, OP_TANH, OP_INTERP, OP_BLEND1,
      OP_BLEND2, OP_TONE1, OP_TONE2, OP_LP, OP_TILT, OP_MIX1, OP_MIX2, OP_OUT
   } op_type;

   typedef struct packed {
      op_type op;
      logic   load_in;
      logic   load_out;
   } cmd_type;

   typedef logic [23:0] tanh_tab_type [0:TANH_DEPTH];

   // shift-subtract quotient, elaboration only
   function automatic longint unsigned udiv(longint unsigned a, longint unsigned b);
      longint unsigned q;
      longint unsigned rem;
      q   = 64'd0;
      rem = 64'd0;
      for (int bi = 63; bi >= 0; bi--) begin
         rem = (rem << 1) | ((a >> bi) & 64'd1);
         q   = q << 1;
         if (rem >= b) begin
            rem = rem - b;
            q   = q | 64'd1;
         end
      end
      return q;
   endfunction

   // e^-2x series (argument / 16, then squared four times), tanh = (1-r)/(1+r)
   function automatic tanh_tab_type build_tanh_table();
      tanh_tab_type      tab;
      longint unsigned   y;
      longint unsigned   z;
      longint unsigned   term;
      longint unsigned   r;
      longint unsigned   num;
      longint unsigned   den;
      longint            sum;
      for (int i = 0; i <= TANH_DEPTH; i++) begin
         y    = (longint'(i) << 33) / TANH_DEPTH;
         z    = y >> 4;
         term = 64'd1 << 30;
         sum  = 64'sd1 << 30;
         for (int n = 1; n <= 16; n++) begin
            term = udiv((term * z + (64'd1 << 29)) >> 30, longint'(n));
            if ((n & 1) == 1) sum = sum - longint'(term);
            else sum = sum + longint'(term);
         end
         r = (sum < 0) ? 64'd0 : longint'(sum);
         for (int k = 0; k < 4; k++) begin
            r = (r * r + (64'd1 << 29)) >> 30;
         end
         if (r > (64'd1 << 30)) r = 64'd1 << 30;
         num    = (64'd1 << 30) - r;
         den    = (64'd1 << 30) + r;
         tab[i] = 24'(udiv((num << 23) + (den >> 1), den));
      end
      return tab;
   endfunction

   localparam tanh_tab_type TANH_TAB = build_tanh_table();

endpackage

`default_nettype wire

/* design/astl_ctrl.sv */
// ----------------------------------------------------------------------------
// astl_ctrl: sample sequencer
// Steps one sample through the shared multiply-accumulate datapath and
// owns the stream handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module astl_ctrl (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  wire               rsp_tready,
   output astl_pkg::cmd_type cmd
);

   astl_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                fire;

   // result register free or being drained this cycle
   assign fire = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         astl_pkg::ST_IDLE:   if (req_tvalid) state_in = astl_pkg::ST_DRIVE;
         astl_pkg::ST_DRIVE:  state_in = astl_pkg::ST_SCALE;
         astl_pkg::ST_SCALE:  state_in = astl_pkg::ST_ARG;
         astl_pkg::ST_ARG:    state_in = astl_pkg::ST_TANH;
         astl_pkg::ST_TANH:   state_in = astl_pkg::ST_INTERP;
         astl_pkg::ST_INTERP: state_in = astl_pkg::ST_BLEND1;
         astl_pkg::ST_BLEND1: state_in = astl_pkg::ST_BLEND2;
         astl_pkg::ST_BLEND2: state_in = astl_pkg::ST_TONE1;
         astl_pkg::ST_TONE1:  state_in = astl_pkg::ST_TONE2;
         astl_pkg::ST_TONE2:  state_in = astl_pkg::ST_LP;
         astl_pkg::ST_LP:     state_in = astl_pkg::ST_TILT;
         astl_pkg::ST_TILT:   state_in = astl_pkg::ST_MIX1;
         astl_pkg::ST_MIX1:   state_in = astl_pkg::ST_MIX2;
         astl_pkg::ST_MIX2:   state_in = astl_pkg::ST_OUT;
         astl_pkg::ST_OUT:    if (fire) state_in = astl_pkg::ST_IDLE;
         default:             state_in = astl_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.op       = astl_pkg::OP_NONE;
      cmd.load_in  = 1'b0;
      cmd.load_out = 1'b0;
      req_tready   = 1'b0;
      case (state_ff)
         astl_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.load_in = req_tvalid;
         end
         astl_pkg::ST_DRIVE:  cmd.op = astl_pkg::OP_DRIVE;
         astl_pkg::ST_SCALE:  cmd.op = astl_pkg::OP_SCALE;
         astl_pkg::ST_ARG:    cmd.op = astl_pkg::OP_ARG;
         astl_pkg::ST_TANH:   cmd.op = astl_pkg::OP_TANH;
         astl_pkg::ST_INTERP: cmd.op = astl_pkg::OP_INTERP;
         astl_pkg::ST_BLEND1: cmd.op = astl_pkg::OP_BLEND1;
         astl_pkg::ST_BLEND2: cmd.op = astl_pkg::OP_BLEND2;
         astl_pkg::ST_TONE1:  cmd.op = astl_pkg::OP_TONE1;
         astl_pkg::ST_TONE2:  cmd.op = astl_pkg::OP_TONE2;
         astl_pkg::ST_LP:     cmd.op = astl_pkg::OP_LP;
         astl_pkg::ST_TILT:   cmd.op = astl_pkg::OP_TILT;
         astl_pkg::ST_MIX1:   cmd.op = astl_pkg::OP_MIX1;
         astl_pkg::ST_MIX2:   cmd.op = astl_pkg::OP_MIX2;
         astl_pkg::ST_OUT: begin
            cmd.op       = astl_pkg::OP_OUT;
            cmd.load_out = fire;
         end
         default: cmd.op = astl_pkg::OP_NONE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= astl_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

/* design/astl_datapath.sv */
// ----------------------------------------------------------------------------
// astl_datapath: shaper, tilt EQ and limiter arithmetic
// Config registers, one shared 35x26 multiplier with a 64-bit accumulator,
// the per-channel tone memory and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module astl_datapath #(
   parameter int CHANNELS = astl_pkg::CHANNELS_DEFAULT
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  astl_pkg::cmd_type                   cmd,
   input  wire                                 csr_we,
   input  wire  [astl_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire  [astl_pkg::CSR_DATA_W-1:0]     csr_data,
   input  wire                                 channel_sel,
   input  wire  signed [23:0]                  in_sample,
   input  wire  signed [23:0]                  prior_out,
   output logic signed [23:0]                  out_sample,
   output logic                                was_limited,
   output logic [22:0]                         over_amount
);

   localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int IDX_W = astl_pkg::TANH_IDX_W;
   localparam int P_W   = astl_pkg::SPAN_SHIFT + IDX_W;

   // config registers
   logic [22:0]        drive_gain_ff, drive_gain_in;
   logic [16:0]        drive_amount_ff, drive_amount_in;
   logic [16:0]        shock_ff, shock_in;
   logic [16:0]        mix_ff, mix_in;
   logic signed [16:0] tilt_ff, tilt_in;
   logic [22:0]        ceiling_ff, ceiling_in;
   logic [24:0]        tone_coef_ff, tone_coef_in;
   logic               accum_ff, accum_in;

   // settings derived from config
   logic [16:0]        sh_ff, sh_in;
   logic [20:0]        bias_ff, bias_in;
   logic [23:0]        thr_ff, thr_in;
   logic [16:0]        amt_ff, amt_in;
   logic               clean_ff, clean_in;
   logic               fold_en_ff, fold_en_in;
   logic [24:0]        a_ff, a_in;
   logic signed [16:0] tilt_sat_ff, tilt_sat_in;
   logic [16:0]        mix_sat_ff, mix_sat_in;

   // per-sample working registers
   logic [CH_W-1:0]    ch_ff, ch_in;
   logic signed [23:0] dry_ff, dry_in;
   logic signed [23:0] prior_ff, prior_in;
   logic signed [63:0] acc_ff, acc_in;
   logic signed [31:0] s_ff, s_in;
   logic [23:0]        lo_ff, lo_in;
   logic signed [24:0] diff_ff, diff_in;
   logic [24:0]        fr_ff, fr_in;
   logic               neg_ff, neg_in;
   logic signed [26:0] d_ff, d_in;
   logic signed [31:0] wet_ff, wet_in;
   logic signed [31:0] lp_ff, lp_in;
   logic signed [34:0] toned_ff, toned_in;
   logic signed [31:0] mem_ff [CHANNELS];
   logic               mem_we;

   logic signed [23:0] out_sample_ff, out_sample_in;
   logic               limited_ff, limited_in;
   logic [22:0]        over_ff, over_in;

   // shared multiplier
   logic signed [34:0] opa;
   logic signed [25:0] opb;
   logic signed [60:0] prod;
   logic               mul_en, mul_add;

   // rounded views of the accumulator
   logic signed [63:0] r9_unused;
   logic signed [63:0] r15, r16, r24, r25;

   // comb temporaries
   logic [16:0]        m_big;
   logic [31:0]        bias_p;
   logic [31:0]        fold_p;
   logic signed [33:0] arg;
   logic [33:0]        mag;
   logic [P_W-1:0]     p;
   logic [IDX_W-1:0]   idx;
   logic [IDX_W:0]     idx_hi;
   logic [23:0]        hi_pt;
   logic signed [26:0] v, dd, t27;
   logic signed [32:0] hp;
   logic signed [36:0] mixed;
   logic [36:0]        mmag, excess;
   logic signed [23:0] lim;
   logic signed [24:0] acc_sum;

   assign r9_unused = '0;
   assign r15 = (acc_ff + 64'sd16384) >>> 15;
   assign r16 = (acc_ff + 64'sd32768) >>> 16;
   assign r24 = (acc_ff + 64'sd8388608) >>> 24;
   assign r25 = (acc_ff + 64'sd16777216) >>> 25;

   // config writes and derived settings
   always_comb begin
      drive_gain_in   = drive_gain_ff;
      drive_amount_in = drive_amount_ff;
      shock_in        = shock_ff;
      mix_in          = mix_ff;
      tilt_in         = tilt_ff;
      ceiling_in      = ceiling_ff;
      tone_coef_in    = tone_coef_ff;
      accum_in        = accum_ff;
      if (csr_we) begin
         case (csr_index)
            astl_pkg::REG_DRIVE_GAIN:   drive_gain_in   = csr_data[22:0];
            astl_pkg::REG_DRIVE_AMOUNT: drive_amount_in = csr_data[16:0];
            astl_pkg::REG_SHOCK_AMOUNT: shock_in        = csr_data[16:0];
            astl_pkg::REG_MIX_AMOUNT:   mix_in          = csr_data[16:0];
            astl_pkg::REG_TILT_AMOUNT:  tilt_in         = csr_data[16:0];
            astl_pkg::REG_CEILING:      ceiling_in      = csr_data[22:0];
            astl_pkg::REG_TONE_COEF:    tone_coef_in    = csr_data[24:0];
            astl_pkg::REG_ACCUMULATE:   accum_in        = csr_data[0];
            default:                    accum_in        = accum_ff;
         endcase
      end

      sh_in   = (shock_ff > astl_pkg::ONE_Q16) ? astl_pkg::ONE_Q16 : shock_ff;
      bias_p  = 32'(sh_ff) * 32'(astl_pkg::BIAS_Q16) + 32'd256;
      bias_in = bias_p[29:9];
      fold_p  = 32'(sh_ff) * 32'(astl_pkg::FOLD_Q16) + 32'd256;
      thr_in  = astl_pkg::ONE_Q23 - 24'(fold_p[31:9]);
      m_big   = (drive_amount_ff > sh_ff) ? drive_amount_ff : sh_ff;
      amt_in  = (m_big > astl_pkg::ONE_Q16) ? astl_pkg::ONE_Q16 : m_big;
      clean_in   = (drive_amount_ff <= astl_pkg::CLEAN_LIMIT)
                   && (sh_ff <= astl_pkg::CLEAN_LIMIT);
      fold_en_in = sh_ff > astl_pkg::FOLD_LIMIT;
      a_in    = (tone_coef_ff > astl_pkg::ONE_Q24) ? astl_pkg::ONE_Q24 : tone_coef_ff;
      if (tilt_ff > $signed(astl_pkg::TILT_MAX)) tilt_sat_in = astl_pkg::TILT_MAX;
      else if (tilt_ff < -$signed(astl_pkg::TILT_MAX)) tilt_sat_in = -astl_pkg::TILT_MAX;
      else tilt_sat_in = tilt_ff;
      mix_sat_in = (mix_ff > astl_pkg::ONE_Q16) ? astl_pkg::ONE_Q16 : mix_ff;
   end

   // sequenced arithmetic
   always_comb begin
      ch_in     = ch_ff;
      dry_in    = dry_ff;
      prior_in  = prior_ff;
      s_in      = s_ff;
      lo_in     = lo_ff;
      diff_in   = diff_ff;
      fr_in     = fr_ff;
      neg_in    = neg_ff;
      d_in      = d_ff;
      wet_in    = wet_ff;
      lp_in     = lp_ff;
      toned_in  = toned_ff;
      mem_we    = 1'b0;
      opa       = '0;
      opb       = '0;
      mul_en    = 1'b0;
      mul_add   = 1'b0;
      out_sample_in = out_sample_ff;
      limited_in    = limited_ff;
      over_in       = over_ff;

      // tanh lookup terms
      arg    = r16[33:0];
      mag    = arg[33] ? 34'(-arg) : 34'(arg);
      p      = P_W'(mag[24:0]) * P_W'(astl_pkg::TANH_DEPTH);
      idx    = p[P_W-1:astl_pkg::SPAN_SHIFT];
      idx_hi = {1'b0, idx} + (IDX_W+1)'(1);
      hi_pt  = astl_pkg::TANH_TAB[idx_hi];

      // interpolation and fold
      v   = $signed({3'b000, lo_ff}) + r25[26:0];
      dd  = neg_ff ? -v : v;
      t27 = $signed({3'b000, thr_ff});
      if (fold_en_ff) begin
         if (dd > t27) dd = (t27 <<< 1) - dd;
         if (dd < -t27) dd = -(t27 <<< 1) - dd;
         if (dd > $signed({3'b000, astl_pkg::CLAMP_Q23}))
            dd = $signed({3'b000, astl_pkg::CLAMP_Q23});
         if (dd < -$signed({3'b000, astl_pkg::CLAMP_Q23}))
            dd = -$signed({3'b000, astl_pkg::CLAMP_Q23});
      end

      hp = 33'(wet_ff) - 33'(lp_ff);

      // limiter
      mixed  = r16[36:0];
      mmag   = mixed[36] ? 37'(-mixed) : 37'(mixed);
      excess = mmag - 37'(ceiling_ff);
      if (mmag > 37'(ceiling_ff)) lim = mixed[36] ? -$signed({1'b0, ceiling_ff})
                                                  : $signed({1'b0, ceiling_ff});
      else lim = mixed[23:0];
      acc_sum = 25'(prior_ff) + 25'(lim);

      if (cmd.load_in) begin
         ch_in    = (CHANNELS == 1) ? '0 : CH_W'(channel_sel);
         dry_in   = in_sample;
         prior_in = prior_out;
      end

      case (cmd.op)
         astl_pkg::OP_DRIVE: begin
            mul_en = 1'b1;
            opa    = 35'(dry_ff);
            opb    = 26'(drive_gain_ff);
         end
         astl_pkg::OP_SCALE: s_in = r16[31:0];
         astl_pkg::OP_ARG: begin
            mul_en = 1'b1;
            if (!s_ff[31]) begin
               opa = 35'(s_ff) + 35'(bias_ff);
               opb = 26'(astl_pkg::SLOPE_POS);
            end else begin
               opa = 35'(s_ff) - 35'(bias_ff);
               opb = 26'(astl_pkg::SLOPE_NEG);
            end
         end
         astl_pkg::OP_TANH: begin
            neg_in = arg[33];
            fr_in  = p[astl_pkg::SPAN_SHIFT-1:0];
            if (mag[33:astl_pkg::SPAN_SHIFT] != '0) begin
               lo_in   = astl_pkg::TANH_TAB[astl_pkg::TANH_DEPTH];
               diff_in = '0;
            end else begin
               lo_in   = astl_pkg::TANH_TAB[idx];
               diff_in = $signed({1'b0, hi_pt}) - $signed({1'b0, astl_pkg::TANH_TAB[idx]});
            end
         end
         astl_pkg::OP_INTERP: begin
            mul_en = 1'b1;
            opa    = 35'(diff_ff);
            opb    = 26'(fr_ff);
         end
         astl_pkg::OP_BLEND1: begin
            d_in   = dd;
            mul_en = 1'b1;
            opa    = 35'(s_ff);
            opb    = 26'(astl_pkg::ONE_Q16 - amt_ff);
         end
         astl_pkg::OP_BLEND2: begin
            mul_en  = 1'b1;
            mul_add = 1'b1;
            opa     = 35'(d_ff);
            opb     = 26'(amt_ff);
         end
         astl_pkg::OP_TONE1: begin
            wet_in = clean_ff ? s_ff : r16[31:0];
            mul_en = 1'b1;
            opa    = 35'(mem_ff[ch_ff]);
            opb    = 26'(a_ff);
         end
         astl_pkg::OP_TONE2: begin
            mul_en  = 1'b1;
            mul_add = 1'b1;
            opa     = 35'(wet_ff);
            opb     = 26'(astl_pkg::ONE_Q24 - a_ff);
         end
         astl_pkg::OP_LP: begin
            mem_we = 1'b1;
            if (r24 > 64'sd2147483647) lp_in = 32'sh7FFFFFFF;
            else if (r24 < -64'sd2147483648) lp_in = 32'sh80000000;
            else lp_in = r24[31:0];
         end
         astl_pkg::OP_TILT: begin
            mul_en = 1'b1;
            opa    = tilt_sat_ff[16] ? 35'(lp_ff) : 35'(hp);
            opb    = 26'(tilt_sat_ff);
         end
         astl_pkg::OP_MIX1: begin
            toned_in = 35'(wet_ff) + r15[34:0];
            mul_en   = 1'b1;
            opa      = 35'(dry_ff);
            opb      = 26'(astl_pkg::ONE_Q16 - mix_sat_ff);
         end
         astl_pkg::OP_MIX2: begin
            mul_en  = 1'b1;
            mul_add = 1'b1;
            opa     = toned_ff;
            opb     = 26'(mix_sat_ff);
         end
         astl_pkg::OP_OUT: begin
            if (cmd.load_out) begin
               limited_in = mmag > 37'(ceiling_ff);
               if (mmag > 37'(ceiling_ff))
                  over_in = (excess > 37'(astl_pkg::S24_MAX)) ? astl_pkg::S24_MAX
                                                              : excess[22:0];
               else
                  over_in = '0;
               if (!accum_ff) out_sample_in = lim;
               else if (acc_sum > 25'sd8388607) out_sample_in = 24'sh7FFFFF;
               else if (acc_sum < -25'sd8388608) out_sample_in = 24'sh800000;
               else out_sample_in = acc_sum[23:0];
            end
         end
         default: mul_en = 1'b0;
      endcase

      prod   = opa * opb;
      acc_in = acc_ff;
      if (mul_en) acc_in = (mul_add ? acc_ff : 64'sd0) + 64'(prod) + r9_unused;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_gain_ff   <= astl_pkg::RST_DRIVE_GAIN;
         drive_amount_ff <= '0;
         shock_ff        <= '0;
         mix_ff          <= astl_pkg::RST_MIX_AMOUNT;
         tilt_ff         <= '0;
         ceiling_ff      <= astl_pkg::RST_CEILING;
         tone_coef_ff    <= astl_pkg::RST_TONE_COEF;
         accum_ff        <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) mem_ff[i] <= '0;
      end else begin
         drive_gain_ff   <= drive_gain_in;
         drive_amount_ff <= drive_amount_in;
         shock_ff        <= shock_in;
         mix_ff          <= mix_in;
         tilt_ff         <= tilt_in;
         ceiling_ff      <= ceiling_in;
         tone_coef_ff    <= tone_coef_in;
         accum_ff        <= accum_in;
         if (mem_we) mem_ff[ch_ff] <= lp_in;
      end
   end

   always_ff @(posedge clock) begin
      sh_ff       <= sh_in;
      bias_ff     <= bias_in;
      thr_ff      <= thr_in;
      amt_ff      <= amt_in;
      clean_ff    <= clean_in;
      fold_en_ff  <= fold_en_in;
      a_ff        <= a_in;
      tilt_sat_ff <= tilt_sat_in;
      mix_sat_ff  <= mix_sat_in;
      ch_ff       <= ch_in;
      dry_ff      <= dry_in;
      prior_ff    <= prior_in;
      acc_ff      <= acc_in;
      s_ff        <= s_in;
      lo_ff       <= lo_in;
      diff_ff     <= diff_in;
      fr_ff       <= fr_in;
      neg_ff      <= neg_in;
      d_ff        <= d_in;
      wet_ff      <= wet_in;
      lp_ff       <= lp_in;
      toned_ff    <= toned_in;
      out_sample_ff <= out_sample_in;
      limited_ff    <= limited_in;
      over_ff       <= over_in;
   end

   assign out_sample  = out_sample_ff;
   assign was_limited = limited_ff;
   assign over_amount = over_ff;

endmodule

`default_nettype wire

/* design/audio_shaper_tilt_limiter.sv */
// ----------------------------------------------------------------------------
// audio_shaper_tilt_limiter: waveshaper with tilt EQ and brickwall limiter
// Top level: sequencer plus shared multiply-accumulate datapath.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel carries one sample transaction: tdata holds in_sample and
//    prior_out, tuser selects the channel (0 left, 1 right).
//  - rsp channel returns one transaction per sample: tdata holds out_sample
//    and over_amount, tuser is the was_limited flag.
//  - csr channel writes one config register per transaction, always ready.
//    Write only while no sample is in flight.
//  - A sample is accepted, then steps through the sequencer; the block is
//    ready again in the cycle that rsp_tvalid rises, and takes no new sample
//    while one is in flight. The pace is set by the single 35x26 multiplier,
//    used once per step through drive, tanh argument, interpolation, blend,
//    tone filter, tilt and dry/wet mix.
//  - The result sits in an output register; when the receiver stalls the
//    next sample is still taken and processed, and the sequencer waits in
//    its last step until the register is free.
//  - Synchronous reset restores register defaults, clears both tone filter
//    memories and drops rsp_tvalid. No clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module audio_shaper_tilt_limiter #(
   parameter int CHANNELS = astl_pkg::CHANNELS_DEFAULT
) (
   input  wire                              clock,
   input  wire                              reset,
   // in_sample [23:0], prior_out [47:24]
   input  wire  [47:0]                      req_tdata,
   // channel_sel [0]
   input  wire                              req_tuser,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   // out_sample [23:0], over_amount [46:24], zero [47]
   output logic [47:0]                      rsp_tdata,
   // was_limited [0]
   output logic                             rsp_tuser,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [astl_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire  [astl_pkg::CSR_DATA_W-1:0]  csr_data
);

   astl_pkg::cmd_type  cmd;
   logic signed [23:0] out_sample;
   logic               was_limited;
   logic [22:0]        over_amount;

   assign csr_ready = 1'b1;

   astl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   astl_datapath #(
      .CHANNELS (CHANNELS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .csr_we      (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .channel_sel (req_tuser),
      .in_sample   (req_tdata[23:0]),
      .prior_out   (req_tdata[47:24]),
      .out_sample  (out_sample),
      .was_limited (was_limited),
      .over_amount (over_amount)
   );

   assign rsp_tdata = {1'b0, over_amount, out_sample};
   assign rsp_tuser = was_limited;

   // one sample in flight: ready drops right after a transaction
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("req_tready high while a sample is in flight");

   // no result can appear in the cycle after a sample is accepted
   a_no_fast_result : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !rsp_tvalid) |=> !rsp_tvalid)
      else $error("result appeared one cycle after acceptance");

   // reset empties the result register
   a_reset_clears : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid set after reset");

   // excess is reported only when the clamp acted
   a_over_flag : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[46:24] == 23'd0))
      else $error("over_amount nonzero without was_limited");

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for audio_shaper_tilt_limiter
// Drives random and directed samples through the block across several
// register settings. A bit-exact fixed-point predictor, kept in a small
// scoreboard class, checks every rsp transaction in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   typedef struct {
      logic [23:0] out_sample;
      logic        was_limited;
      logic [22:0] over_amount;
   } shaper_result_type;

   // --- predictor state and expected-result store ---
   class shaper_scoreboard;
      longint            tanh_pts [0:astl_pkg::TANH_DEPTH];
      longint            gain, drv, shk, mixf, tilt, ceil_lvl, coef;
      bit                accum;
      longint            tone_mem [2];
      shaper_result_type pending [$];
      int                errors;

      function void init_state();
         for (int i = 0; i <= astl_pkg::TANH_DEPTH; i++) tanh_pts[i] = build_point(i);
         gain = 65536; drv = 0; shk = 0; mixf = 65536; tilt = 0;
         ceil_lvl = 8083000; coef = 13000000; accum = 0;
         tone_mem[0] = 0; tone_mem[1] = 0;
         errors = 0;
      endfunction

      // integer e^-2x series, squared four times
      function longint build_point(int i);
         longint unsigned y, z, term, r, num, den;
         longint sum;
         y = (longint'(i) << 33) / astl_pkg::TANH_DEPTH;
         z = y >> 4;
         term = 64'd1 << 30;
         sum = 64'sd1 << 30;
         for (int n = 1; n <= 16; n++) begin
            term = ((term * z + (64'd1 << 29)) >> 30) / longint'(n);
            if (n % 2 == 1) sum -= longint'(term);
            else sum += longint'(term);
         end
         r = (sum < 0) ? 0 : longint'(sum);
         for (int k = 0; k < 4; k++) r = (r * r + (64'd1 << 29)) >> 30;
         if (r > (64'd1 << 30)) r = 64'd1 << 30;
         num = (64'd1 << 30) - r;
         den = (64'd1 << 30) + r;
         return longint'(((num << 23) + den / 2) / den);
      endfunction

      // round half toward +inf; >>> on signed longint floors
      function longint round_shift(longint v, int sh);
         return (v + (longint'(1) << (sh - 1))) >>> sh;
      endfunction

      function longint clip(longint v, longint lo, longint hi);
         return v < lo ? lo : (v > hi ? hi : v);
      endfunction

      function longint tanh_lookup(longint a);
         longint mag, v, p, idx, fr;
         mag = a < 0 ? -a : a;
         if (mag >= (longint'(1) << astl_pkg::SPAN_SHIFT))
            v = tanh_pts[astl_pkg::TANH_DEPTH];
         else begin
            p = mag * astl_pkg::TANH_DEPTH;
            idx = p >>> astl_pkg::SPAN_SHIFT;
            fr = p & ((longint'(1) << astl_pkg::SPAN_SHIFT) - 1);
            v = tanh_pts[idx] + round_shift((tanh_pts[idx+1] - tanh_pts[idx]) * fr,
                                            astl_pkg::SPAN_SHIFT);
         end
         return a < 0 ? -v : v;
      endfunction

      function longint waveshape(longint x);
         longint s, sh, bias, d, t, amt;
         s = round_shift(x * gain, 16);
         sh = shk > 65536 ? 65536 : shk;
         if (drv <= 6 && sh <= 6) return s;
         bias = round_shift(sh * 9830, 9);
         if (s >= 0) d = tanh_lookup(round_shift((s + bias) * 104858, 16));
         else d = tanh_lookup(round_shift((s - bias) * 85197, 16));
         if (sh > 65) begin
            t = 8388608 - round_shift(sh * 39322, 9);
            if (d > t) d = 2 * t - d;
            if (d < -t) d = -2 * t - d;
            d = clip(d, -10066330, 10066330);
         end
         amt = drv > sh ? drv : sh;
         if (amt > 65536) amt = 65536;
         return round_shift(s * (65536 - amt) + d * amt, 16);
      endfunction

      function void write_reg(logic [astl_pkg::CSR_INDEX_W-1:0] idx,
                              logic [astl_pkg::CSR_DATA_W-1:0] val);
         case (idx)
            astl_pkg::REG_DRIVE_GAIN:   gain = val[22:0];
            astl_pkg::REG_DRIVE_AMOUNT: drv = val[16:0];
            astl_pkg::REG_SHOCK_AMOUNT: shk = val[16:0];
            astl_pkg::REG_MIX_AMOUNT:   mixf = val[16:0];
            astl_pkg::REG_TILT_AMOUNT:  tilt = longint'($signed(val[16:0]));
            astl_pkg::REG_CEILING:      ceil_lvl = val[22:0];
            astl_pkg::REG_TONE_COEF:    coef = val[24:0];
            astl_pkg::REG_ACCUMULATE:   accum = val[0];
            default: ;
         endcase
      endfunction

      // note an accepted sample: compute and queue its result
      function void note_sample(bit ch, logic [23:0] din, logic [23:0] prior_in);
         longint dry, prior, wet, a, tl, mx, lp, hp, toned, mixed, mag, lim, res;
         shaper_result_type r;
         dry = longint'($signed(din));
         prior = longint'($signed(prior_in));
         wet = waveshape(dry);
         a = coef > (1 << 24) ? (1 << 24) : coef;
         tl = clip(tilt, -32768, 32768);
         mx = mixf > 65536 ? 65536 : mixf;
         lp = round_shift(a * tone_mem[ch] + ((longint'(1) << 24) - a) * wet, 24);
         lp = clip(lp, -64'sd2147483648, 64'sd2147483647);
         tone_mem[ch] = lp;
         hp = wet - lp;
         toned = wet + round_shift(tl * (tl >= 0 ? hp : lp), 15);
         mixed = round_shift(dry * (65536 - mx) + toned * mx, 16);
         mag = mixed < 0 ? -mixed : mixed;
         lim = mixed;
         r.was_limited = 0;
         r.over_amount = 0;
         if (mag > ceil_lvl) begin
            lim = mixed < 0 ? -ceil_lvl : ceil_lvl;
            r.was_limited = 1;
            r.over_amount = 23'(clip(mag - ceil_lvl, 0, 8388607));
         end
         res = accum ? clip(prior + lim, -8388608, 8388607) : lim;
         r.out_sample = 24'(res);
         pending.push_back(r);
      endfunction

      function void check_result(logic [47:0] data, logic flag);
         shaper_result_type e;
         if (pending.size() == 0) begin
            $error("unexpected rsp transaction data=%h", data);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (data[23:0] !== e.out_sample) begin
            $error("out_sample exp %h got %h", e.out_sample, data[23:0]); errors++;
         end
         if (data[46:24] !== e.over_amount) begin
            $error("over_amount exp %h got %h", e.over_amount, data[46:24]); errors++;
         end
         if (flag !== e.was_limited) begin
            $error("was_limited exp %b got %b", e.was_limited, flag); errors++;
         end
         if (data[47] !== 1'b0) begin
            $error("tdata pad exp 0 got %b", data[47]); errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic [47:0] req_tdata = '0;
   logic req_tuser = 0, req_tvalid = 0, req_tready;
   logic [47:0] rsp_tdata;
   logic rsp_tuser, rsp_tvalid;
   logic rsp_tready = 0;
   logic csr_valid = 0, csr_ready;
   logic [astl_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [astl_pkg::CSR_DATA_W-1:0] csr_data = '0;

   shaper_scoreboard sb = new();
   int sender_idle_pct = 0;     // chance in % of a gap before each sample
   int receiver_idle_pct = 0;   // chance in % of rsp_tready low per cycle
   int hold_off_cycles = 0;     // long receiver stall, counted below

   always #5 clock = ~clock;

   audio_shaper_tilt_limiter DUT (
      .clock, .reset, .req_tdata, .req_tuser, .req_tvalid, .req_tready,
      .rsp_tdata, .rsp_tuser, .rsp_tvalid, .rsp_tready,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   // monitors: note accepted input transactions, check results
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         sb.note_sample(req_tuser, req_tdata[23:0], req_tdata[47:24]);
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata, rsp_tuser);
   end

   // receiver: random stalls plus an optional long hold-off
   always @(posedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   task automatic send_sample(bit ch, logic [23:0] din, logic [23:0] prior_in);
      if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= ch;
      req_tdata <= {prior_in, din};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic stop_sending();
      req_tvalid <= 1'b0;
   endtask

   // wait until every result is in, then let the pipeline settle
   task automatic drain();
      stop_sending();
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // leaves csr_valid high; the caller drops it after the last write
   task automatic write_csr(logic [astl_pkg::CSR_INDEX_W-1:0] idx,
                            logic [astl_pkg::CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, val);
   endtask

   task automatic random_sample();
      logic [23:0] din;
      case ($urandom_range(3))
         0: din = 24'($urandom);
         1: din = 24'($signed(12'($urandom)));           // small level
         2: din = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
         default: din = 24'($signed(20'($urandom)));
      endcase
      send_sample($urandom_range(1), din, 24'($urandom));
   endtask

   // one setting of all registers, random or extreme
   task automatic program_all(int kind);
      logic [astl_pkg::CSR_DATA_W-1:0] v [8];
      case (kind)
         0: begin  // low extremes
            v = '{65536, 0, 0, 0, 25'h1_8000, 4194304, 0, 0};
         end
         1: begin  // high extremes
            v = '{6553600, 65536, 65536, 65536, 32768, 8388607, 16777216, 1};
         end
         2: begin  // out-of-range values that saturate inside the block
            v = '{23'h7FFFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 25'h1_7FFF,
                  23'h7FFFFF, 25'h1FFFFFF, 1};
         end
         3: begin  // shaper bypass edge, fold just off
            v = '{$urandom_range(65536, 655360), 6, 65, $urandom_range(65536),
                  25'h1_0000, $urandom_range(4194304, 8388607),
                  $urandom_range(16777216), 0};
         end
         default: begin
            v = '{$urandom_range(65536, 6553600), $urandom_range(65536),
                  $urandom_range(65536), $urandom_range(65536), 25'($urandom),
                  $urandom_range(4194304, 8388607), 25'($urandom),
                  $urandom_range(1)};
         end
      endcase
      for (int i = 0; i < 8; i++) write_csr(astl_pkg::CSR_INDEX_W'(i), v[i]);
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes of sample fields on default settings, then clamps
      send_sample(0, 24'h000000, 24'h000000);
      send_sample(1, 24'h7FFFFF, 24'h7FFFFF);
      send_sample(0, 24'h800000, 24'h800000);
      send_sample(1, 24'hFFFFFF, 24'h000001);
      send_sample(0, 24'h400000, 24'hC00000);
      drain();
      program_all(1);  // full drive, fold, accumulate saturation
      send_sample(0, 24'h7FFFFF, 24'h7FFFFF);
      send_sample(1, 24'h800000, 24'h800000);
      send_sample(0, 24'h000001, 24'h7FFFFF);
      send_sample(1, 24'hFFFFFF, 24'h800000);
      send_sample(0, 24'h100000, 24'h000000);
      drain();
      program_all(2);
      for (int i = 0; i < 5; i++) random_sample();
      drain();
      program_all(0);
      for (int i = 0; i < 5; i++) random_sample();
      drain();
      program_all(3);
      for (int i = 0; i < 5; i++) random_sample();
      drain();

      // random phases: receiver idle, sender idle, then neither
      for (int phase = 0; phase < 9; phase++) begin
         sender_idle_pct = phase < 3 ? 35 : (phase < 6 ? 86 : 0);
         receiver_idle_pct = phase < 3 ? 86 : (phase < 6 ? 35 : 0);
         program_all(phase == 7 ? 1 : (phase == 8 ? 0 : 4));
         if (phase == 6) hold_off_cycles <= 400;  // fill up and back-pressure
         for (int i = 0; i < 100; i++) begin
            random_sample();
            if (i == 50) begin  // pause until everything has come back
               stop_sending();
               @(posedge clock);
               while (sb.pending.size() != 0) @(posedge clock);
            end
         end
         drain();
      end

      if (sb.errors == 0) $display("audio_shaper_tilt_limiter test passed");
      else $display("audio_shaper_tilt_limiter test failed");
      $finish;
   end

   initial begin
      sb.init_state();
      #5ms;
      $display("audio_shaper_tilt_limiter test failed");
      $finish;
   end

endmodule

/* filelist.f */
design/astl_pkg.sv
design/astl_ctrl.sv
design/astl_datapath.sv
design/audio_shaper_tilt_limiter.sv
tb/sv/tb_top.sv
